FILE: rtl/core/tedc_pkg.sv
// Shared types and constants for the timed event dedup cache.
package tedc_pkg;

  localparam int unsigned PidW    = 22;
  localparam int unsigned StampW  = 32;
  localparam int unsigned WindowW = 8;

  localparam logic [WindowW-1:0] WindowReset = 8'd2;

  // Event beat payload.
  typedef struct packed {
    logic [PidW-1:0]   process_id;
    logic              event_kind;
    logic [StampW-1:0] now_seconds;
  } evt_t;

  // Result beat payload.
  typedef struct packed {
    logic duplicate;
  } res_t;

  // Configuration beat payload.
  typedef struct packed {
    logic [WindowW-1:0] window_seconds;
  } cfg_t;

  // Lookup token walking the cell row.
  typedef struct packed {
    logic              vld;
    logic [PidW-1:0]   pid;
    logic              kind;
    logic [StampW-1:0] now;
    logic              hit;
  } tok_t;

  // Entry write request broadcast to the row.
  typedef struct packed {
    logic [PidW-1:0]   pid;
    logic              kind;
    logic [StampW-1:0] stamp;
  } entry_t;

endpackage

FILE: rtl/core/tedc_chan_if.sv
// Valid/ready channel interface with a typed payload.
interface tedc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/tedc_cell.sv
// One cache entry cell: compares the passing token and forwards it.
module tedc_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [tedc_pkg::WindowW-1:0] window_i,
  input  tedc_pkg::tok_t           tok_i,
  output tedc_pkg::tok_t           tok_o,
  input  logic                     wr_en_i,
  input  tedc_pkg::entry_t         wr_i
);

  logic                         vld_q;
  tedc_pkg::entry_t             ent_q;
  tedc_pkg::tok_t               tok_q;
  logic [tedc_pkg::StampW-1:0]  age;
  logic                         recent;
  logic                         match;

  // Signed age: negative (future stamp) always counts as recent.
  assign age    = tok_i.now - ent_q.stamp;
  assign recent = age[tedc_pkg::StampW-1] |
                  (age < {{(tedc_pkg::StampW-tedc_pkg::WindowW){1'b0}}, window_i});
  assign match  = vld_q && (ent_q.pid == tok_i.pid) && (ent_q.kind == tok_i.kind) && recent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      ent_q <= '0;
      tok_q <= '0;
    end else begin
      tok_q.vld  <= tok_i.vld;
      tok_q.pid  <= tok_i.pid;
      tok_q.kind <= tok_i.kind;
      tok_q.now  <= tok_i.now;
      tok_q.hit  <= tok_i.hit | match;
      if (wr_en_i) begin
        vld_q <= 1'b1;
        ent_q <= wr_i;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: rtl/core/timed_event_dedup_cache_top.sv
// Timed event dedup cache: top level with the cell row and control.
// The token of an event walks the cell row, one cell a cycle; its result then enters the output register
// (held in drain while that register is full). A new event is taken only once the last result is in it.
// A finished result waits in the output register; the next event is taken meanwhile.
// Reset (rst_ni low, async): valid bits, insert pointer and control clear, window goes to 2.
// No clearing pass: the block takes events right after reset.
module timed_event_dedup_cache_top #(
  parameter int unsigned ENTRIES = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tedc_chan_if.sink   evt_i,
  tedc_chan_if.source res_o,
  tedc_chan_if.sink   cfg_i
);

  localparam int unsigned PtrW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN
  } state_e;

  state_e                           state_q;
  logic [PtrW-1:0]                  ptr_q;
  logic [tedc_pkg::WindowW-1:0]     window_q;
  logic                             out_vld_q;
  logic                             out_dup_q;
  logic                             pend_dup_q;

  tedc_pkg::tok_t                   tok [ENTRIES+1];
  tedc_pkg::tok_t                   tok_last;
  tedc_pkg::entry_t                 wr_ent;
  logic [ENTRIES-1:0]               wr_sel;
  logic                             evt_acc;
  logic                             out_free;
  logic                             out_load;
  logic                             insert;

  // Handshakes: config always taken; events only when no token is in flight.
  assign cfg_i.ready = 1'b1;
  assign evt_i.ready = (state_q == S_IDLE);
  assign evt_acc     = evt_i.valid & evt_i.ready;

  assign res_o.valid             = out_vld_q;
  assign res_o.payload.duplicate = out_dup_q;

  // Output register can take a new result this cycle.
  assign out_free = !out_vld_q || res_o.ready;

  // A result enters the output register: fresh from the row, or held in drain.
  assign out_load = out_free &&
                    (((state_q == S_WALK) && tok_last.vld) || (state_q == S_DRAIN));

  // Token enters cell 0 on the accepted event beat.
  always_comb begin
    tok[0].vld  = evt_acc;
    tok[0].pid  = evt_i.payload.process_id;
    tok[0].kind = evt_i.payload.event_kind;
    tok[0].now  = evt_i.payload.now_seconds;
    tok[0].hit  = 1'b0;
  end

  assign tok_last = tok[ENTRIES];

  // A miss leaving the last cell is written at the round-robin pointer.
  assign insert       = tok_last.vld && !tok_last.hit;
  assign wr_ent.pid   = tok_last.pid;
  assign wr_ent.kind  = tok_last.kind;
  assign wr_ent.stamp = tok_last.now;

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      wr_sel[k] = insert && (ptr_q == PtrW'(k));
    end
  end

  // Cell row: each cell holds one entry and forwards the token every cycle.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tedc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .window_i (window_q),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .wr_en_i  (wr_sel[g]),
      .wr_i     (wr_ent)
    );
  end

  // Control: state, pointer, window register and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ptr_q      <= '0;
      window_q   <= tedc_pkg::WindowReset;
      out_vld_q  <= 1'b0;
      out_dup_q  <= 1'b0;
      pend_dup_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        window_q <= cfg_i.payload.window_seconds;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
        out_dup_q <= (state_q == S_DRAIN) ? pend_dup_q : tok_last.hit;
      end else if (out_vld_q && res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (insert) begin
        ptr_q <= (ptr_q == PtrW'(ENTRIES - 1)) ? '0 : ptr_q + PtrW'(1);
      end
      case (state_q)
        S_IDLE: begin
          if (evt_acc) begin
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (tok_last.vld) begin
            if (out_free) begin
              state_q <= S_IDLE;
            end else begin
              pend_dup_q <= tok_last.hit;
              state_q    <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          // Earlier result still unread: hold this one until the slot frees.
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A token accepted on an event beat reaches the end of the row after walking through every cell.
  a_walk_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_acc |-> ##ENTRIES tok_last.vld)
    else $error("token did not leave the cell row on time");

  // A token only leaves the row while the control waits for it.
  a_tok_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_last.vld |-> state_q == S_WALK)
    else $error("token left the row outside the walk");

  // Insert pointer stays inside the row.
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PtrW'(ENTRIES - 1))
    else $error("insert pointer out of range");

  // At most one cell is written per cycle.
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wr_sel))
    else $error("more than one cell written");
`endif

endmodule
